>>> hdl/mrf_pkg.sv
// Shared types and constants for the message replay filter.
// No dependencies; imported by every module of the block.
package mrf_pkg;

	// nonce ring geometry
	localparam int CACHE_DEPTH = 16;
	localparam int KEY_BITS    = 64;
	localparam int IDX_W       = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

	// field widths
	localparam int NOW_W     = 63;
	localparam int TS_W      = 64;
	localparam int LEN_W     = 32;
	localparam int KEY_IN_W  = 64;
	localparam int SEQ_W     = 64;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// divide-by-1000 unit: radix-16, one digit per step
	localparam int DIVISOR   = 1000;
	localparam int DIV_W     = 64;
	localparam int DIGIT_W   = 4;
	localparam int DIV_STEPS = DIV_W / DIGIT_W;
	localparam int REM_W     = 10;
	localparam int T_W       = REM_W + DIGIT_W;

	// ttl in ms fits 32 bits times 1000
	localparam int TTL_MS_W = CFG_W + REM_W;
	// signed age difference, wide enough for any seconds pair
	localparam int AGE_W    = 66;

	// step counter covers both the divider and the ring scan
	localparam int STEPS  = (CACHE_DEPTH > DIV_STEPS) ? CACHE_DEPTH : DIV_STEPS;
	localparam int STEP_W = $clog2(STEPS);

	// timestamps above this value are in ms
	localparam logic signed [TS_W-1:0] MS_THRESHOLD = 64'sd1000000000000;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_TOO_OLD  = 3'd1,
		ST_FUTURE   = 3'd2,
		ST_PAYLOAD  = 3'd3,
		ST_NO_NONCE = 3'd4,
		ST_REUSED   = 3'd5,
		ST_SEQ      = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_AGE     = 2'd0,
		CFG_FUTURE_SKEW = 2'd1,
		CFG_MAX_PAYLOAD = 2'd2,
		CFG_NONCE_TTL   = 2'd3
	} cfg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              div_step;
		logic              scan_step;
		logic [STEP_W-1:0] idx;
		logic              check;
		logic              commit;
	} mrf_cmd_t;

endpackage

>>> hdl/message_replay_filter_top.sv
// Message replay filter, top level.
// Depends on mrf_pkg, mrf_ctrl, mrf_datapath (and mrf_div1000 below it).
//
// Usage:
//  - Request channel (in_valid/in_ready): one message header per request.
//    Result channel (out_valid/out_ready): one status and accepted flag each.
//  - Config port: cfg_we writes cfg_wdata into register cfg_index
//    (0 max age s, 1 future skew s, 2 max payload bytes, 3 nonce ttl s).
//    Write only while no request is in flight.
//  - Sequence: once the request is taken, the two divide-by-1000 units
//    produce one quotient digit per cycle, overlapped with a scan of the
//    16-entry nonce ring, one entry per cycle; the check state then forms
//    the age difference and the decide state decides and commits.
//  - Requests: one at a time; the next is taken only once the previous
//    one has committed its result.
//  - Stalls: a finished result waits in the output register; the next
//    request is taken and processed meanwhile, and holds in its decide
//    cycle until the register frees up. Nothing is dropped.
//  - Reset: config returns to 300/30/16384/300, the nonce ring empties,
//    the sequence baseline is forgotten, no result is pending.
module message_replay_filter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mrf_pkg::NOW_W-1:0]        now_ms,
	input  logic signed [mrf_pkg::TS_W-1:0]  msg_timestamp,
	input  logic [mrf_pkg::LEN_W-1:0]        payload_len,
	input  logic                             nonce_present,
	input  logic [mrf_pkg::KEY_IN_W-1:0]     nonce_key,
	input  logic signed [mrf_pkg::SEQ_W-1:0] seq_number,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mrf_pkg::STATUS_W-1:0]     status,
	output logic                             accepted,
	input  logic                             cfg_we,
	input  logic [mrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mrf_pkg::CFG_W-1:0]        cfg_wdata
);
	import mrf_pkg::*;

	mrf_cmd_t cmd;

	mrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mrf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.now_ms        (now_ms),
		.msg_timestamp (msg_timestamp),
		.payload_len   (payload_len),
		.nonce_present (nonce_present),
		.nonce_key     (nonce_key),
		.seq_number    (seq_number),
		.status        (status),
		.accepted      (accepted)
	);

endmodule

>>> hdl/mrf_div1000.sv
// Sequential divide-by-1000, one radix-16 quotient digit per step.
// Depends on mrf_pkg.
module mrf_div1000 (
	input  logic                       clk,
	input  logic                       load,
	input  logic                       step,
	input  logic [mrf_pkg::DIV_W-1:0]  dividend,
	output logic [mrf_pkg::DIV_W-1:0]  quotient
);
	import mrf_pkg::*;

	logic [DIV_W-1:0]   num_q;
	logic [DIV_W-1:0]   quo_q;
	logic [REM_W-1:0]   rem_q;
	logic [T_W-1:0]     t;
	logic [T_W-1:0]     base;
	logic [DIGIT_W-1:0] d;

	// partial remainder < 16000; pick the largest multiple of 1000 not above it
	always_comb begin
		t    = {rem_q, num_q[DIV_W-1 -: DIGIT_W]};
		d    = '0;
		base = '0;
		for (int k = 1; k < (1 << DIGIT_W); k++) begin
			if (t >= T_W'(k * DIVISOR)) begin
				d    = DIGIT_W'(k);
				base = T_W'(k * DIVISOR);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (step) begin
			num_q <= num_q << DIGIT_W;
			rem_q <= REM_W'(t - base);
			quo_q <= {quo_q[DIV_W-DIGIT_W-1:0], d};
		end
	end

	assign quotient = quo_q;

endmodule

>>> hdl/mrf_datapath.sv
// Datapath: config registers, request latch, two divide-by-1000 units,
// nonce ring with valid bits, sequence tracking and result register.
// Depends on mrf_pkg and mrf_div1000.
module mrf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mrf_pkg::mrf_cmd_t              cmd,
	input  logic                           cfg_we,
	input  logic [mrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrf_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [mrf_pkg::NOW_W-1:0]      now_ms,
	input  logic signed [mrf_pkg::TS_W-1:0] msg_timestamp,
	input  logic [mrf_pkg::LEN_W-1:0]      payload_len,
	input  logic                           nonce_present,
	input  logic [mrf_pkg::KEY_IN_W-1:0]   nonce_key,
	input  logic signed [mrf_pkg::SEQ_W-1:0] seq_number,
	output logic [mrf_pkg::STATUS_W-1:0]   status,
	output logic                           accepted
);
	import mrf_pkg::*;

	// config
	logic [CFG_W-1:0] max_age_q, skew_q, max_payload_q, nonce_ttl_q;

	// latched request
	logic [NOW_W-1:0]    now_q;
	logic [TS_W-1:0]     ts_q;
	logic [LEN_W-1:0]    plen_q;
	logic                present_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [TTL_MS_W-1:0] ttl_ms_q;

	// divider results
	logic [DIV_W-1:0] now_quo, ts_quo;

	// check results
	logic signed [AGE_W-1:0] diff_q;
	logic                    plen_big_q;
	logic                    seq_bad_q;

	// nonce ring
	logic [KEY_BITS-1:0]    key_mem  [CACHE_DEPTH];
	logic [NOW_W-1:0]       time_mem [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] valid_q;
	logic [CACHE_DEPTH-1:0] clr_q;
	logic                   found_q;
	logic [IDX_W-1:0]       head_q;

	// sequence
	logic             seq_seen_q;
	logic [SEQ_W-1:0] last_seq_q;

	// result
	logic [STATUS_W-1:0] status_q;
	logic                accepted_q;

	// scan signals
	logic [IDX_W-1:0]    sidx;
	logic [KEY_BITS-1:0] rd_key;
	logic [NOW_W-1:0]    rd_time;
	logic [NOW_W-1:0]    age_ms;
	logic                expired;
	logic                key_hit;

	// decision signals
	logic signed [AGE_W-1:0] ts_sel;
	logic signed [AGE_W-1:0] old_t, fut_t;
	logic                    too_old, future, seq_neg, nonce_reached;
	status_t                 st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q     <= CFG_W'(300);
			skew_q        <= CFG_W'(30);
			max_payload_q <= CFG_W'(16384);
			nonce_ttl_q   <= CFG_W'(300);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_AGE:     max_age_q     <= cfg_wdata;
				CFG_FUTURE_SKEW: skew_q        <= cfg_wdata;
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_wdata;
				CFG_NONCE_TTL:   nonce_ttl_q   <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q     <= now_ms;
			ts_q      <= msg_timestamp;
			plen_q    <= payload_len;
			present_q <= nonce_present;
			key_q     <= nonce_key[KEY_BITS-1:0];
			seq_q     <= seq_number;
			ttl_ms_q  <= TTL_MS_W'(nonce_ttl_q) * TTL_MS_W'(DIVISOR);
		end
	end

	mrf_div1000 u_div_now (
		.clk      (clk),
		.load     (cmd.load),
		.step     (cmd.div_step),
		.dividend ({1'b0, now_ms}),
		.quotient (now_quo)
	);

	mrf_div1000 u_div_ts (
		.clk      (clk),
		.load     (cmd.load),
		.step     (cmd.div_step),
		.dividend (msg_timestamp),
		.quotient (ts_quo)
	);

	// ms timestamps are positive, so the unsigned quotient is the right one
	always_comb begin
		if ($signed(ts_q) > MS_THRESHOLD) begin
			ts_sel = AGE_W'($signed({1'b0, ts_quo}));
		end else begin
			ts_sel = AGE_W'($signed(ts_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			diff_q     <= AGE_W'($signed({1'b0, now_quo})) - ts_sel;
			plen_big_q <= plen_q > max_payload_q;
			seq_bad_q  <= seq_seen_q && (seq_q <= last_seq_q);
		end
	end

	// ring scan, one entry per step
	assign sidx    = cmd.idx[IDX_W-1:0];
	assign rd_key  = key_mem[sidx];
	assign rd_time = time_mem[sidx];
	assign age_ms  = now_q - rd_time;
	// an entry stored later than now never expires
	assign expired = (now_q > rd_time) && (age_ms > NOW_W'(ttl_ms_q));
	assign key_hit = rd_key == key_q;

	// age check: too old if diff > max_age, future if diff < -skew
	assign old_t   = AGE_W'($signed({1'b0, max_age_q})) - diff_q;
	assign fut_t   = diff_q + AGE_W'($signed({1'b0, skew_q}));
	assign too_old = old_t[AGE_W-1];
	assign future  = fut_t[AGE_W-1];
	assign seq_neg = seq_q[SEQ_W-1];

	assign nonce_reached = !(too_old || future || plen_big_q || !present_q);

	always_comb begin
		priority if (too_old) begin
			st = ST_TOO_OLD;
		end else if (future) begin
			st = ST_FUTURE;
		end else if (plen_big_q) begin
			st = ST_PAYLOAD;
		end else if (!present_q) begin
			st = ST_NO_NONCE;
		end else if (found_q) begin
			st = ST_REUSED;
		end else if (!seq_neg && seq_bad_q) begin
			st = ST_SEQ;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			clr_q      <= '0;
			found_q    <= 1'b0;
			head_q     <= '0;
			seq_seen_q <= 1'b0;
			last_seq_q <= '0;
		end else begin
			if (cmd.load) begin
				clr_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_step && valid_q[sidx] && !found_q) begin
				if (expired) begin
					clr_q[sidx] <= 1'b1;
				end else if (key_hit) begin
					found_q <= 1'b1;
				end
			end
			// expired entries visited by the scan drop out even on a reuse hit
			if (cmd.commit && nonce_reached) begin
				for (int i = 0; i < CACHE_DEPTH; i++) begin
					if (clr_q[i]) begin
						valid_q[i] <= 1'b0;
					end
				end
				if (!found_q) begin
					valid_q[head_q] <= 1'b1;
					head_q <= (head_q == IDX_W'(CACHE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					if (!seq_neg) begin
						if (!seq_seen_q) begin
							seq_seen_q <= 1'b1;
							last_seq_q <= seq_q;
						end else if (!seq_bad_q) begin
							last_seq_q <= seq_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && nonce_reached && !found_q) begin
			key_mem[head_q]  <= key_q;
			time_mem[head_q] <= now_q;
		end
		if (cmd.commit) begin
			status_q   <= st;
			accepted_q <= st == ST_OK;
		end
	end

	assign status   = status_q;
	assign accepted = accepted_q;

endmodule

>>> hdl/mrf_ctrl.sv
// Controller: sequences divide/scan steps, the check cycle and the
// commit into the result register. Depends on mrf_pkg.
module mrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mrf_pkg::mrf_cmd_t cmd
);
	import mrf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_CHECK,
		S_DECIDE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load      = in_valid && in_ready;
		cmd.div_step  = (state_q == S_RUN) &&
		                ({1'b0, cnt_q} < (STEP_W + 1)'(DIV_STEPS));
		cmd.scan_step = (state_q == S_RUN) &&
		                ({1'b0, cnt_q} < (STEP_W + 1)'(CACHE_DEPTH));
		cmd.idx       = cnt_q;
		cmd.check     = state_q == S_CHECK;
		// result register must be free before the state is updated
		cmd.commit    = (state_q == S_DECIDE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(STEPS - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (cmd.commit) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

>>> bench/message_replay_filter_top_tb.sv
// Self-checking bench for message_replay_filter_top: directed edge cases, then random
// header streams under five register settings, idle bursts on both channels in all but the last.
// Depends on mrf_pkg and the RTL under hdl/ only.
module message_replay_filter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE   = 20;
	localparam int PHASE_ITEMS = 170;
	localparam logic [NOW_W-1:0] T0 = 63'd1700000000000;
	localparam longint S0 = 64'sd1700000000;

	typedef struct {
		logic [NOW_W-1:0]        now;
		logic signed [TS_W-1:0]  ts;
		logic [LEN_W-1:0]        len;
		logic                    present;
		logic [KEY_IN_W-1:0]     key;
		logic signed [SEQ_W-1:0] seq;
	} header_t;

	// Holds its own copy of the filter state and the statuses still owed by the block.
	class verdict_board;
		logic [CFG_W-1:0] max_age, skew, max_len, ttl;
		logic [KEY_IN_W-1:0] ring_key[CACHE_DEPTH];
		logic [NOW_W-1:0] ring_stamp[CACHE_DEPTH];
		bit ring_live[CACHE_DEPTH];
		int head, fill;
		bit seq_seen;
		logic [SEQ_W-1:0] last_seq;
		status_t verdicts_due[$];
		int errors, results;
		int by_status[7];

		function void clear();
			max_age = 300;
			skew = 30;
			max_len = 16384;
			ttl = 300;
			foreach (ring_live[i]) ring_live[i] = 0;
			head = 0;
			fill = 0;
			seq_seen = 0;
			last_seq = '0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_MAX_AGE: max_age = v;
				CFG_FUTURE_SKEW: skew = v;
				CFG_MAX_PAYLOAD: max_len = v;
				CFG_NONCE_TTL: ttl = v;
				default: ;
			endcase
		endfunction

		// scan drops expired entries; a live match stops the scan, otherwise insert
		function bit replay_hit(logic [KEY_IN_W-1:0] key, logic [NOW_W-1:0] now);
			logic [63:0] ttl_ms;
			logic [63:0] held;
			ttl_ms = 64'(ttl) * 64'd1000;
			for (int i = 0; i < fill; i++) begin
				if (!ring_live[i]) continue;
				held = {1'b0, now} - {1'b0, ring_stamp[i]};
				if (now > ring_stamp[i] && held > ttl_ms) begin
					ring_live[i] = 0;
					continue;
				end
				if (ring_key[i] == key) return 1;
			end
			ring_key[head] = key;
			ring_stamp[head] = now;
			ring_live[head] = 1;
			head = (head + 1) % CACHE_DEPTH;
			if (fill < CACHE_DEPTH) fill++;
			return 0;
		endfunction

		function status_t screen_header(header_t h);
			logic [NOW_W-1:0] now_sec;
			logic signed [65:0] ts_sec, age;
			logic [KEY_IN_W-1:0] kmask;
			status_t st;
			now_sec = h.now / 1000;
			if (h.ts > MS_THRESHOLD) ts_sec = h.ts / 64'sd1000;
			else ts_sec = h.ts;
			age = $signed({3'b000, now_sec}) - ts_sec;
			kmask = {KEY_IN_W{1'b1}} >> (KEY_IN_W - KEY_BITS);
			st = ST_OK;
			if (age > $signed({34'd0, max_age})) st = ST_TOO_OLD;
			else if (age < -$signed({34'd0, skew})) st = ST_FUTURE;
			else if (h.len > max_len) st = ST_PAYLOAD;
			else if (!h.present) st = ST_NO_NONCE;
			else if (replay_hit(h.key & kmask, h.now)) st = ST_REUSED;
			else if (!h.seq[SEQ_W-1]) begin
				if (!seq_seen) begin
					seq_seen = 1;
					last_seq = h.seq;
				end else if (h.seq <= last_seq) st = ST_SEQ;
				else last_seq = h.seq;
			end
			return st;
		endfunction

		function void note_request(header_t h);
			verdicts_due.push_back(screen_header(h));
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic acc);
			status_t want;
			if (verdicts_due.size() == 0) begin
				$error("status: expected no result, got %0d", st);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			results++;
			by_status[want]++;
			if (st !== want) begin
				$error("status: expected %0d, got %0d", want, st);
				errors++;
			end
			if (acc !== (want == ST_OK)) begin
				$error("accepted: expected %0d, got %0d", want == ST_OK, acc);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [NOW_W-1:0] now_ms = '0;
	logic signed [TS_W-1:0] msg_timestamp = '0;
	logic [LEN_W-1:0] payload_len = '0;
	logic nonce_present = 1'b0;
	logic [KEY_IN_W-1:0] nonce_key = '0;
	logic signed [SEQ_W-1:0] seq_number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic accepted;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_MAX_AGE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	verdict_board board = new();
	logic [NOW_W-1:0] cur_now;
	longint seq_next;
	logic [KEY_IN_W-1:0] nonce_pool[POOL_SIZE];
	bit idle_on;
	int stall_left;
	int cycle_count;
	int directed_count;

	always #1 clk = ~clk;

	message_replay_filter_top i_dut (.*);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check, then pick the ready level for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(status, accepted);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_request(header_t h);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= h.now;
		msg_timestamp <= h.ts;
		payload_len <= h.len;
		nonce_present <= h.present;
		nonce_key <= h.key;
		seq_number <= h.seq;
		do @(posedge clk); while (!in_ready);
		board.note_request(h);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_W-1:0] age, skew, len, ttl);
		cfg_idx_t order[4];
		logic [CFG_W-1:0] v[4];
		order = '{CFG_MAX_AGE, CFG_FUTURE_SKEW, CFG_MAX_PAYLOAD, CFG_NONCE_TTL};
		v = '{age, skew, len, ttl};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_wdata <= v[i];
			@(posedge clk);
			board.write_reg(order[i], v[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic header_t mk(logic [NOW_W-1:0] now, longint ts, logic [LEN_W-1:0] len,
			bit present, logic [KEY_IN_W-1:0] key, longint seq);
		header_t h;
		h.now = now;
		h.ts = ts;
		h.len = len;
		h.present = present;
		h.key = key;
		h.seq = seq;
		return h;
	endfunction

	task automatic run_directed();
		logic [KEY_IN_W-1:0] dk[9];
		header_t list[$];
		foreach (dk[i]) dk[i] = {$urandom, $urandom};
		list.push_back(mk(T0, S0, 0, 1, dk[0], 5));                        // baseline seq
		list.push_back(mk(T0 + 1, longint'(T0), 100, 1, dk[1], 6));        // ms timestamp
		list.push_back(mk(T0 + 2, S0 - 301, 10, 1, dk[2], 7));
		list.push_back(mk(T0 + 3, S0 - 300, 10, 1, dk[2], 7));             // age at the limit
		list.push_back(mk(T0 + 4, S0 + 31, 10, 1, dk[3], 8));
		list.push_back(mk(T0 + 5, S0 + 30, 10, 1, dk[3], 8));              // skew at the limit
		list.push_back(mk(T0 + 6, S0, 16385, 1, dk[4], 9));
		list.push_back(mk(T0 + 7, S0, 16384, 1, dk[4], 9));
		list.push_back(mk(T0 + 8, S0, 10, 0, dk[5], 10));
		list.push_back(mk(T0 + 9, S0, 10, 1, dk[0], 10));
		list.push_back(mk(T0 + 10, S0, 10, 1, dk[5], 9));                  // equal seq, nonce kept
		list.push_back(mk(T0 + 11, S0, 10, 1, dk[6], 3));
		list.push_back(mk(T0 + 12, S0, 10, 1, dk[7], -1));                 // seq absent
		list.push_back(mk(T0 + 13, S0, 10, 1, dk[5], 20));
		list.push_back(mk(T0 - 5000, S0 - 5, 10, 1, dk[1], 21));           // clock went back
		list.push_back(mk(T0 + 301002, S0 + 301, 10, 1, dk[0], 22));       // nonce aged out
		list.push_back(mk(0, 0, 0, 1, 0, 0));
		list.push_back(mk({NOW_W{1'b1}}, 64'sh7fffffffffffffff, 0, 1, '1,
			64'sh8000000000000000));
		list.push_back(mk(0, 64'sh8000000000000000, 0, 1, dk[8], 23));
		list.push_back(mk(0, 64'sd1000000000000, 0, 1, dk[8], 23));      // threshold is seconds
		list.push_back(mk(63'd1000000000001, 64'sd1000000000001, 0, 1, dk[8], 23));
		list.push_back(mk(T0 + 400000, S0 + 400, 32'hffffffff, 1, dk[8], 24));
		list.push_back(mk(T0 + 400001, S0 + 400, 0, 1, '1, 24));           // stored in the future
		directed_count = list.size();
		foreach (list[i]) send_request(list[i]);
	endtask

	// mostly plausible headers on a moving clock; a share of fully random noise
	function automatic header_t random_header();
		header_t h;
		longint nsec, ts_sec;
		int pick;
		if ($urandom_range(0, 99) < 12) begin
			h.now = NOW_W'({$urandom, $urandom});
			h.ts = {$urandom, $urandom};
			h.len = $urandom;
			h.present = $urandom_range(0, 1) != 0;
			h.key = {$urandom, $urandom};
			h.seq = {$urandom, $urandom};
			return h;
		end
		pick = $urandom_range(0, 19);
		if (pick == 0) cur_now = cur_now - $urandom_range(0, 20000);
		else if (pick < 3 && board.ttl < 1000000)
			cur_now = cur_now + 63'(board.ttl) * 1000 + $urandom_range(0, 2000);
		else if (pick < 3) cur_now = cur_now + $urandom_range(0, 400000);
		else cur_now = cur_now + $urandom_range(0, 2500);
		h.now = cur_now;
		nsec = longint'(cur_now / 1000);
		case ($urandom_range(0, 7))
			0: ts_sec = nsec - longint'(board.max_age) - $urandom_range(0, 1);
			1: ts_sec = nsec + longint'(board.skew) + $urandom_range(0, 1);
			2: ts_sec = nsec - longint'($urandom_range(0, 2000000)) + 1000000;
			default: ts_sec = nsec + $urandom_range(0, 4) - 2;
		endcase
		h.ts = $urandom_range(0, 1) ? ts_sec * 1000 + $urandom_range(0, 999) : ts_sec;
		pick = $urandom_range(0, 9);
		if (pick < 8) h.len = $urandom_range(0, 2000);
		else if (pick == 8) h.len = board.max_len + $urandom_range(0, 1);
		else h.len = $urandom;
		h.present = $urandom_range(0, 14) != 0;
		if ($urandom_range(0, 9) < 7) h.key = nonce_pool[$urandom_range(0, POOL_SIZE - 1)];
		else h.key = {$urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			seq_next += $urandom_range(1, 3);
			h.seq = seq_next;
		end else if (pick < 17) begin
			h.seq = seq_next - $urandom_range(0, 2);
		end else begin
			h.seq = {1'b1, 31'($urandom), $urandom};
		end
		return h;
	endfunction

	initial begin
		board.clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1;
		run_directed();
		drain();
		cur_now = T0 + 500000;
		seq_next = 100;
		foreach (nonce_pool[i]) nonce_pool[i] = {$urandom, $urandom};
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_regs(60, 5, 1500, 20);
				1: write_regs(0, 0, 0, 0);
				2: write_regs('1, '1, '1, '1);
				3: write_regs($urandom_range(1, 600), $urandom_range(0, 60),
					$urandom_range(100, 20000), $urandom_range(1, 400));
				default: write_regs(300, 30, 16384, 300);
			endcase
			idle_on = (p != 4);
			for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_header());
			drain();
		end
		repeat (16) @(posedge clk);
		$display("screened %0d headers (%0d directed) under five register settings, %0d passed",
			board.results, directed_count, board.by_status[ST_OK]);
		$display("rejected: old %0d, future %0d, size %0d, no nonce %0d, replay %0d, order %0d",
			board.by_status[ST_TOO_OLD], board.by_status[ST_FUTURE],
			board.by_status[ST_PAYLOAD], board.by_status[ST_NO_NONCE],
			board.by_status[ST_REUSED], board.by_status[ST_SEQ]);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
